/* rtl/bmf_pkg.sv */
`default_nettype none

package bmf_pkg;

    // Data and position widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int OCOL_W     = 10;
    localparam int RCNT_W     = 13;
    localparam int ROW_LIMIT  = 4096;

    // Configuration port
    localparam int CFG_COLS_W = 11;
    localparam int CFG_ROWS_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd1;
    localparam logic [CFG_COLS_W-1:0] NUM_COLS_RST = 11'd480;
    localparam logic [CFG_ROWS_W-1:0] NUM_ROWS_RST = 13'd640;

    // Default line length
    localparam int MAX_COLS_DEF = 1024;

    // Mean by nine: floor(sum / 9) == (sum * 7282) >> 16 for sum <= 2295
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
    localparam int RECIP_SHIFT = 16;

    // Result group queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;
    localparam int OQ_CNT_W = 4;

    typedef struct packed {
        logic has_a;   // output one row up, one column left
        logic mean;    // that output is a full 3x3 mean
        logic has_b;   // output one row up at the last column
        logic has_c;   // output the pixel itself on the last row
    } flags_t;

    typedef struct packed {
        logic [PIX_W-1:0]  value;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
    } result_t;

    typedef struct packed {
        result_t [2:0] slot;   // slot 0 leaves first
        logic    [1:0] cnt;    // 1..3 results in use
    } group_t;

endpackage

`default_nettype wire

/* rtl/bmf_ram.sv */
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/bmf_pos.sv */
`default_nettype none

module bmf_pos
    import bmf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [CFG_COLS_W-1:0]       num_cols,
    input  wire logic [CFG_ROWS_W-1:0]       num_rows,
    input  wire logic                        accept,
    input  wire logic                        start_of_frame,
    output logic      [ROW_W-1:0]            row,
    output logic      [$clog2(MAX_COLS)-1:0] col,
    output flags_t                           flags
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CLEN_W = $clog2(MAX_COLS + 1);
    localparam int CMP_W  = (CLEN_W > CFG_COLS_W) ? CLEN_W : CFG_COLS_W;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CMP_W-1:0]  cols_ext, cols_eff, col_inc;
    logic [RCNT_W-1:0] rows_eff, row_adv, row_inc;
    logic [ROW_W-1:0]  row_base;
    logic [COL_W-1:0]  col_base;
    logic              col_wrap, col_last, row_last;

    // Clamp the frame size to the supported range
    always_comb begin
        cols_ext = CMP_W'(num_cols);
        if (cols_ext == '0) begin
            cols_eff = CMP_W'(1);
        end else if (cols_ext > CMP_W'(MAX_COLS)) begin
            cols_eff = CMP_W'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
        if (num_rows == '0) begin
            rows_eff = RCNT_W'(1);
        end else if (RCNT_W'(num_rows) > RCNT_W'(ROW_LIMIT)) begin
            rows_eff = RCNT_W'(ROW_LIMIT);
        end else begin
            rows_eff = RCNT_W'(num_rows);
        end
    end

    // Resolve the position of this request
    always_comb begin
        row_base = start_of_frame ? '0 : row_reg;
        col_base = start_of_frame ? '0 : col_reg;
        col_wrap = CMP_W'(col_base) >= cols_eff;
        row_adv  = col_wrap ? (RCNT_W'(row_base) + RCNT_W'(1)) : RCNT_W'(row_base);
        col      = col_wrap ? '0 : col_base;
        row      = (row_adv >= rows_eff) ? '0 : row_adv[ROW_W-1:0];

        col_inc  = CMP_W'(col) + CMP_W'(1);
        row_inc  = RCNT_W'(row) + RCNT_W'(1);
        col_last = col_inc >= cols_eff;
        row_last = row_inc >= rows_eff;

        flags.has_a = (row != '0) && (col != '0);
        flags.mean  = (row >= ROW_W'(2)) && (col >= COL_W'(2));
        flags.has_b = (row != '0) && col_last;
        flags.has_c = row_last;

        // Advance, wrapping at the row and frame ends
        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : row_inc[ROW_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bmf_win.sv */
`default_nettype none

module bmf_win
    import bmf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire logic [PIX_W-1:0]            in_pixel,
    input  wire logic [ROW_W-1:0]            in_row,
    input  wire logic [$clog2(MAX_COLS)-1:0] in_col,
    input  wire flags_t                      in_flags,
    output logic      [1:0]                  busy,
    output logic                             grp_valid,
    output group_t                           grp
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int LINE_W = 2 * PIX_W;
    localparam int PROD_W = SUM_W + RECIP_W;

    // Stage 1: line read returns
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    flags_t            s1_flags_reg;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [LINE_W-1:0] ram_rdata, line_rd, line_wr;
    logic [PIX_W-1:0]  win_reg  [0:8];
    logic [PIX_W-1:0]  win_next [0:8];
    logic [SUM_W-1:0]  sum_next;

    // Stage 2: mean and result packing
    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic [PIX_W-1:0]  s2_center_reg, s2_above_reg, s2_pix_reg;
    logic [ROW_W-1:0]  s2_row_reg;
    logic [COL_W-1:0]  s2_col_reg;
    flags_t            s2_flags_reg;

    logic [PROD_W-1:0] prod;
    result_t           res_a, res_b, res_c;

    // Line store: upper byte two rows up, lower byte one row up
    bmf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (line_wr),
        .re    (in_valid),
        .raddr (in_col),
        .rdata (ram_rdata)
    );

    // Forward the write of the previous request when it hits the same column
    assign line_rd      = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign line_wr      = {line_rd[PIX_W-1:0], s1_pix_reg};
    assign fwd_hit_next = in_valid && s1_valid_reg && (in_col == s1_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            if (in_valid) begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_pix_reg   <= in_pixel;
            s1_row_reg   <= in_row;
            s1_col_reg   <= in_col;
            s1_flags_reg <= in_flags;
            fwd_data_reg <= line_wr;
        end
    end

    // Shift the window left and load the new right column, then sum it
    always_comb begin
        win_next = win_reg;
        for (int k = 0; k < 3; k++) begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3+1]   = win_reg[k*3+2];
        end
        win_next[2] = line_rd[LINE_W-1:PIX_W];
        win_next[5] = line_rd[PIX_W-1:0];
        win_next[8] = s1_pix_reg;
        sum_next = '0;
        for (int k = 0; k < 9; k++) begin
            sum_next = sum_next + SUM_W'(win_next[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_sum_reg    <= sum_next;
            s2_center_reg <= win_next[4];
            s2_above_reg  <= line_rd[PIX_W-1:0];
            s2_pix_reg    <= s1_pix_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_flags_reg  <= s1_flags_reg;
        end
    end

    // Divide by nine through the reciprocal and build the three results
    always_comb begin
        prod = PROD_W'(s2_sum_reg) * PROD_W'(RECIP_9);

        res_a.value = s2_flags_reg.mean ? PIX_W'(prod >> RECIP_SHIFT) : s2_center_reg;
        res_a.row   = s2_row_reg - ROW_W'(1);
        res_a.col   = OCOL_W'(s2_col_reg - COL_W'(1));

        res_b.value = s2_above_reg;
        res_b.row   = s2_row_reg - ROW_W'(1);
        res_b.col   = OCOL_W'(s2_col_reg);

        res_c.value = s2_pix_reg;
        res_c.row   = s2_row_reg;
        res_c.col   = OCOL_W'(s2_col_reg);
    end

    // Pack present results in order into the group
    always_comb begin
        grp.slot[2] = res_c;
        if (s2_flags_reg.has_a) begin
            grp.slot[0] = res_a;
            grp.slot[1] = s2_flags_reg.has_b ? res_b : res_c;
        end else begin
            grp.slot[0] = s2_flags_reg.has_b ? res_b : res_c;
            grp.slot[1] = res_c;
        end
        grp.cnt = 2'(s2_flags_reg.has_a) + 2'(s2_flags_reg.has_b) + 2'(s2_flags_reg.has_c);
        grp_valid = s2_valid_reg && (grp.cnt != 2'd0);
    end

    assign busy = 2'(s1_valid_reg) + 2'(s2_valid_reg);

endmodule

`default_nettype wire

/* rtl/bmf_outq.sv */
`default_nettype none

module bmf_outq
    import bmf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire group_t              push_grp,
    output logic      [OQ_CNT_W-1:0] count,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [PIX_W-1:0]    m_value,
    output logic      [ROW_W-1:0]    m_out_row,
    output logic      [OCOL_W-1:0]   m_out_col,
    output logic                     m_last
);

    group_t                mem_reg [0:OQ_DEPTH-1];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CNT_W-1:0]   count_reg, count_next;
    logic [1:0]            sub_reg, sub_next;
    group_t                head;
    result_t               cur;
    logic                  take, pop;

    // Present the current result of the head group
    always_comb begin
        head      = mem_reg[rd_ptr_reg];
        cur       = head.slot[sub_reg];
        m_valid   = count_reg != '0;
        m_value   = cur.value;
        m_out_row = cur.row;
        m_out_col = cur.col;
        m_last    = sub_reg == (head.cnt - 2'd1);
        take      = m_valid && m_ready;
        pop       = take && m_last;
        sub_next  = take ? (m_last ? 2'd0 : sub_reg + 2'd1) : sub_reg;
        count_next = count_reg + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end

    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
            count_reg <= count_next;
            sub_reg   <= sub_next;
        end
    end

    // Hold group payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule

`default_nettype wire

/* rtl/box_mean_filter_3x3.sv */
`default_nettype none

// 3x3 box mean filter on an 8-bit raster pixel stream. Interior pixels are
// replaced by floor(sum of the 3x3 neighborhood / 9); pixels of the first and
// last rows and columns pass unchanged. Each result carries its row and
// column; results trail the input by one row and one column and keep raster
// order except on the last row, where its own pixels are interleaved. m_last
// marks the final result caused by one input request. A request with
// s_start_of_frame set restarts at row 0, column 0. The block takes one pixel
// per cycle and emits one result per cycle while s_ready and m_ready are
// high: a pixel of the last row yields two results on average, so there
// s_ready holds the input back once the eight-group result queue has filled;
// the extra result at a row end is absorbed by that queue without pausing
// the input. The two previous rows live in one line RAM of MAX_COLS words
// read and written once per pixel; it needs no clearing after reset. The
// user must write num_cols and num_rows only while the block is idle; the
// block itself does not enforce this.
module box_mean_filter_3x3
    import bmf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel,
    input  wire logic                  s_start_of_frame,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [PIX_W-1:0]      m_value,
    output logic      [ROW_W-1:0]      m_out_row,
    output logic      [OCOL_W-1:0]     m_out_col,
    output logic                       m_last
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic [CFG_COLS_W-1:0] num_cols_reg;
    logic [CFG_ROWS_W-1:0] num_rows_reg;
    logic                  accept;
    logic [ROW_W-1:0]      pos_row;
    logic [COL_W-1:0]      pos_col;
    flags_t                pos_flags;
    logic [1:0]            busy;
    logic                  grp_valid;
    group_t                grp;
    logic [OQ_CNT_W-1:0]   oq_count;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= NUM_COLS_RST;
            num_rows_reg <= NUM_ROWS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_NUM_COLS: num_cols_reg <= cfg_wdata[CFG_COLS_W-1:0];
                REG_NUM_ROWS: num_rows_reg <= cfg_wdata[CFG_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Admit a request only when the queue has room for everything in flight
    assign s_ready = (oq_count + OQ_CNT_W'(busy)) < OQ_CNT_W'(OQ_DEPTH);
    assign accept  = s_valid && s_ready;

    bmf_pos #(
        .MAX_COLS (MAX_COLS)
    ) u_pos (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .num_cols       (num_cols_reg),
        .num_rows       (num_rows_reg),
        .accept         (accept),
        .start_of_frame (s_start_of_frame),
        .row            (pos_row),
        .col            (pos_col),
        .flags          (pos_flags)
    );

    bmf_win #(
        .MAX_COLS (MAX_COLS)
    ) u_win (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_pixel  (s_pixel),
        .in_row    (pos_row),
        .in_col    (pos_col),
        .in_flags  (pos_flags),
        .busy      (busy),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    bmf_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (grp_valid),
        .push_grp  (grp),
        .count     (oq_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_last    (m_last)
    );

endmodule

`default_nettype wire
